// File: src/stx_etx_frame_checker_unit_defines.svh
// Assertion macros used by the frame checker parser.
`ifndef STX_ETX_FRAME_CHECKER_UNIT_DEFINES_SVH
`define STX_ETX_FRAME_CHECKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, ignored while reset is held.
`define SEFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, also evaluated across reset.
`define SEFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SEFC_ASSERT(lbl, prop, msg)
`define SEFC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/sefc_pkg.sv
// Shared types, constants and the hex digit decoder of the frame checker.
`default_nettype none

package sefc_pkg;

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_F   = 8'h46;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_PAYLOAD = 3'd1,
    PH_HIGH    = 3'd2,
    PH_LOW     = 3'd3,
    PH_TAIL    = 3'd4,
    PH_BAD     = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       frame_last;
  } item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       frame_end;
    logic       frame_ok;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_digit_t;

  // Uppercase ASCII hex digit decode; ok is low for anything else.
  function automatic hex_digit_t hex_decode(input logic [7:0] ch);
    hex_digit_t d;
    logic [7:0] diff;
    d    = '0;
    diff = '0;
    if (ch inside {[CHAR_0:CHAR_9]}) begin
      diff     = ch - CHAR_0;
      d.ok     = 1'b1;
      d.nibble = diff[3:0];
    end else if (ch inside {[CHAR_A:CHAR_F]}) begin
      diff     = ch - CHAR_A + 8'd10;
      d.ok     = 1'b1;
      d.nibble = diff[3:0];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: src/stx_etx_frame_checker_unit.sv
// Top level of the STX/ETX framed byte checker with XOR checksum.
//
// Usage: the input channel carries one word per byte of a frame, in_byte with
// frame_last set on the final byte. A frame is STX (0x02), payload bytes, ETX
// (0x03), two uppercase ASCII hex checksum digits and at least one trailing
// byte. The output channel returns exactly one word for every input word:
// payload_valid and payload_byte forward each payload byte, frame_end marks
// the word of the final byte, and frame_ok tells whether the frame's
// structure was sound and its checksum equaled the XOR of the payload.
// A consumer should keep forwarded bytes only once frame_ok confirms them.
//
// A word accepted from the input channel is captured in the input register, and
// its result is then written to the result register. Throughput is one word per
// cycle while the receiver does not stall, set by the update of the parse phase,
// running XOR and high nibble between the two registers.
//
// Reset clears both valid flags and returns the parser to waiting for a start
// byte. When the receiver stalls, the result word holds steady; the input
// register still takes one more word while empty, and only then in_stall
// rises, so no word is lost or repeated.
`default_nettype none

module stx_etx_frame_checker_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       frame_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic       frame_end,
  output logic       frame_ok
);
  import sefc_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    step;
  result_t parsed;
  result_t result_q;

  assign in_item.in_byte    = in_byte;
  assign in_item.frame_last = frame_last;

  sefc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .advance    (advance),
    .in_stall   (in_stall),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // The parser state moves exactly when the held word enters the result register.
  assign step = held_valid && advance;

  sefc_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held_item),
    .result (parsed)
  );

  sefc_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (held_valid),
    .result_in  (parsed),
    .out_stall  (out_stall),
    .advance    (advance),
    .out_valid  (out_valid),
    .result_out (result_q)
  );

  assign payload_valid = result_q.payload_valid;
  assign payload_byte  = result_q.payload_byte;
  assign frame_end     = result_q.frame_end;
  assign frame_ok      = result_q.frame_ok;

endmodule

`default_nettype wire

// File: src/sefc_in_stage.sv
// Input register stage that captures one word from the input channel.
`default_nettype none

module sefc_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  sefc_pkg::item_t in_item,
  input  logic            advance,
  output logic            in_stall,
  output logic            held_valid,
  output sefc_pkg::item_t held_item
);
  import sefc_pkg::*;

  // The held word is free to move on whenever the result stage can take it.
  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: src/sefc_parser.sv
// Frame parser: phase state machine, running XOR and checksum compare.
`default_nettype none
`include "stx_etx_frame_checker_unit_defines.svh"

module sefc_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  sefc_pkg::item_t   item,
  output sefc_pkg::result_t result
);
  import sefc_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] running_xor, running_xor_next;
  logic [3:0] high_nibble, high_nibble_next;
  hex_digit_t digit;

  assign digit = hex_decode(item.in_byte);

  // Next state.
  always_comb begin
    phase_next       = PH_BAD;
    running_xor_next = running_xor;
    high_nibble_next = high_nibble;
    case (phase)
      PH_START: begin
        phase_next = (item.in_byte == STX_BYTE) ? PH_PAYLOAD : PH_BAD;
      end
      PH_PAYLOAD: begin
        if (item.in_byte == ETX_BYTE) begin
          phase_next = PH_HIGH;
        end else begin
          running_xor_next = running_xor ^ item.in_byte;
          phase_next       = PH_PAYLOAD;
        end
      end
      PH_HIGH: begin
        if (digit.ok) begin
          high_nibble_next = digit.nibble;
          phase_next       = PH_LOW;
        end
      end
      PH_LOW: begin
        if (digit.ok && ({high_nibble, digit.nibble} == running_xor)) begin
          phase_next = PH_TAIL;
        end
      end
      PH_TAIL: begin
        phase_next = PH_TAIL;
      end
      default: begin
        phase_next = PH_BAD;
      end
    endcase
    // The last byte of a frame always returns everything to its reset value.
    if (item.frame_last) begin
      phase_next       = PH_START;
      running_xor_next = '0;
      high_nibble_next = '0;
    end
  end

  // Outputs.
  always_comb begin
    result               = '0;
    result.frame_end     = item.frame_last;
    result.frame_ok      = item.frame_last && (phase == PH_TAIL);
    if ((phase == PH_PAYLOAD) && (item.in_byte != ETX_BYTE)) begin
      result.payload_valid = 1'b1;
      result.payload_byte  = item.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      running_xor <= '0;
      high_nibble <= '0;
    end else if (step) begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
      high_nibble <= high_nibble_next;
    end
  end

  `SEFC_ASSERT_ALWAYS(a_reset_start, rst |=> (phase == PH_START && running_xor == 8'h00), "parser not cleared by reset")
  `SEFC_ASSERT(a_last_clears, (step && item.frame_last) |=> (phase == PH_START && running_xor == 8'h00 && high_nibble == 4'h0), "state not cleared after last byte")
  `SEFC_ASSERT(a_tail_holds, (step && phase == PH_TAIL && !item.frame_last) |=> (phase == PH_TAIL), "trailing phase left before frame end")
  `SEFC_ASSERT(a_bad_holds, (step && phase == PH_BAD && !item.frame_last) |=> (phase == PH_BAD), "rejected frame recovered before frame end")

endmodule

`default_nettype wire

// File: src/sefc_out_stage.sv
// Result register that holds one word for the output channel.
`default_nettype none

module sefc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sefc_pkg::result_t result_in,
  input  logic              out_stall,
  output logic              advance,
  output logic              out_valid,
  output sefc_pkg::result_t result_out
);
  import sefc_pkg::*;

  // The register can take a new word when empty or when its word leaves now.
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && advance) begin
      result_out <= result_in;
    end
  end

endmodule

`default_nettype wire
